[design/sbw_pkg.sv]
// Shared types, constants and the arctangent table for the scan beam transform.
`default_nettype none

package sbw_pkg;

    // Default block parameters
    localparam int unsigned SBW_BEAM_COUNT     = 1024;
    localparam int unsigned SBW_TRIG_FRAC_BITS = 15;

    // CORDIC datapath: Q30 vector, angle in 2^-24 turn units
    localparam int unsigned CORDIC_STAGES = 24;
    localparam int unsigned XW            = 34;
    localparam int unsigned ZW            = 25;
    localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

    // Configuration register reset values
    localparam logic [15:0] MAX_RANGE_RST   = 16'd4000;
    localparam logic [15:0] ANGLE_STEP_RST  = 16'd66;
    localparam logic [15:0] START_ANGLE_RST = 16'd21845;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_RANGE   = 2'd0,
        CFG_ANGLE_STEP  = 2'd1,
        CFG_START_ANGLE = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic [15:0] max_range;
        logic [15:0] angle_step;
        logic [15:0] start_angle;
    } cfg_t;

    typedef struct packed {
        logic [9:0]         beam_index;
        logic [15:0]        range_mm;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic [15:0]        robot_yaw;
    } in_t;

    typedef struct packed {
        logic signed [31:0] obstacle_x;
        logic signed [31:0] obstacle_y;
        logic [9:0]         source_beam;
    } out_t;

    // Sample fields that ride along the pipeline
    typedef struct packed {
        logic [9:0]         beam;
        logic [15:0]        range;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
    } side_t;

    typedef struct packed {
        side_t side;
        quad_t quad;
    } track_t;

    // Arctangent of 2^-i in 2^-24 turn units
    function automatic logic signed [ZW-1:0] cordic_atan(input int unsigned idx);
        logic signed [ZW-1:0] val;
        unique case (idx)
            0:       val = ZW'(2097152);
            1:       val = ZW'(1238021);
            2:       val = ZW'(654136);
            3:       val = ZW'(332050);
            4:       val = ZW'(166669);
            5:       val = ZW'(83416);
            6:       val = ZW'(41718);
            7:       val = ZW'(20860);
            8:       val = ZW'(10430);
            9:       val = ZW'(5215);
            10:      val = ZW'(2608);
            11:      val = ZW'(1304);
            12:      val = ZW'(652);
            13:      val = ZW'(326);
            14:      val = ZW'(163);
            15:      val = ZW'(81);
            16:      val = ZW'(41);
            17:      val = ZW'(20);
            18:      val = ZW'(10);
            19:      val = ZW'(5);
            20:      val = ZW'(3);
            21:      val = ZW'(1);
            22:      val = ZW'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[design/scan_beam_to_world_point_top.sv]
// Top level of the scan beam to world point transform: config registers and pipeline.
// Register stages: 2 front, 24 CORDIC, 3 back. Dropped samples leave no result.
// Throughput: one request per cycle while the output is taken; every stage has its own
// valid bit and advances whenever it is empty or its successor moves, so bubbles close
// up under output stall. Reset (aresetn low, synchronous) empties the pipeline
// and loads max_range 4000, angle_step 66, start_angle 21845.
`default_nettype none

module scan_beam_to_world_point_top import sbw_pkg::*; #(
    parameter int unsigned BEAM_COUNT     = SBW_BEAM_COUNT,
    parameter int unsigned TRIG_FRAC_BITS = SBW_TRIG_FRAC_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]          cfg_wdata,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_t                  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_t                      m_data
);

    cfg_t                 cfg_reg, cfg_next;
    logic                 fr_valid, fr_ready;
    track_t               fr_track;
    logic signed [ZW-1:0] fr_z;
    logic                 cd_valid, cd_ready;
    track_t               cd_track;
    logic signed [XW-1:0] cd_cos, cd_sin;

    // Register writes; unknown indexes are ignored
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_MAX_RANGE:   cfg_next.max_range   = cfg_wdata;
                CFG_ANGLE_STEP:  cfg_next.angle_step  = cfg_wdata;
                CFG_START_ANGLE: cfg_next.start_angle = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_range   <= MAX_RANGE_RST;
            cfg_reg.angle_step  <= ANGLE_STEP_RST;
            cfg_reg.start_angle <= START_ANGLE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sbw_front #(
        .BEAM_COUNT (BEAM_COUNT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_track (fr_track),
        .out_z     (fr_z)
    );

    sbw_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_track  (fr_track),
        .in_z      (fr_z),
        .out_valid (cd_valid),
        .out_ready (cd_ready),
        .out_track (cd_track),
        .out_cos   (cd_cos),
        .out_sin   (cd_sin)
    );

    sbw_scale #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cd_valid),
        .in_ready  (cd_ready),
        .in_track  (cd_track),
        .in_cos    (cd_cos),
        .in_sin    (cd_sin),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

`ifndef SYNTHESIS
    // An empty output stage lets every stage advance, so input is open
    assert property (@(posedge aclk) disable iff (!aresetn) !m_valid |-> s_ready)
        else $error("input blocked while output stage empty");

    // A taken output frees the whole chain
    assert property (@(posedge aclk) disable iff (!aresetn) m_ready |-> s_ready)
        else $error("input blocked while output is being taken");

    // Out-of-scan beams never reach the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_data.source_beam) < BEAM_COUNT))
        else $error("result from beam outside the scan");
`endif

endmodule

`default_nettype wire

[design/sbw_front.sv]
// Front end: sample filter, beam angle and quadrant split, two register stages.
`default_nettype none

module sbw_front import sbw_pkg::*; #(
    parameter int unsigned BEAM_COUNT = SBW_BEAM_COUNT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire in_t                  in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output track_t                    out_track,
    output logic signed [ZW-1:0]      out_z
);

    logic              a_valid_reg, a_valid_next;
    logic [15:0]       a_angle_reg, a_angle_next;
    side_t             a_side_reg, a_side_next;
    logic              b_valid_reg, b_valid_next;
    track_t            b_track_reg, b_track_next;
    logic signed [ZW-1:0] b_z_reg, b_z_next;

    logic              en_a, en_b;
    logic              keep;
    logic [25:0]       step_prod;
    logic [15:0]       shifted;
    logic [15:0]       resid;

    // Advance a stage when it is empty or the next one moves
    assign en_b     = !b_valid_reg || out_ready;
    assign en_a     = !a_valid_reg || en_b;
    assign in_ready = en_a;

    // Drop out-of-scan beams and ranges at or beyond the limit
    assign keep = (32'(in_data.beam_index) < BEAM_COUNT) &&
                  (in_data.range_mm < cfg.max_range);

    // Beam angle, wrapping at one turn
    always_comb begin
        step_prod     = {6'd0, in_data.beam_index} * {10'd0, cfg.angle_step};
        a_angle_next  = step_prod[15:0] - cfg.start_angle + in_data.robot_yaw;
        a_side_next.beam  = in_data.beam_index;
        a_side_next.range = in_data.range_mm;
        a_side_next.rx    = in_data.robot_x;
        a_side_next.ry    = in_data.robot_y;
        a_valid_next  = en_a ? (in_valid && keep) : a_valid_reg;
    end

    // Split angle into quadrant and residual in 2^-24 turn units
    always_comb begin
        shifted           = a_angle_reg + 16'd8192;
        b_track_next.quad = quad_t'(shifted[15:14]);
        b_track_next.side = a_side_reg;
        resid             = a_angle_reg - {shifted[15:14], 14'd0};
        b_z_next          = {{(ZW-24){resid[15]}}, resid, 8'd0};
        b_valid_next      = en_b ? a_valid_reg : b_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_angle_reg <= a_angle_next;
            a_side_reg  <= a_side_next;
        end
        if (en_b) begin
            b_track_reg <= b_track_next;
            b_z_reg     <= b_z_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_track = b_track_reg;
    assign out_z     = b_z_reg;

endmodule

`default_nettype wire

[design/sbw_cordic.sv]
// Rotation-mode CORDIC, one register stage per iteration.
`default_nettype none

module sbw_cordic import sbw_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire track_t               in_track,
    input  wire logic signed [ZW-1:0] in_z,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output track_t                    out_track,
    output logic signed [XW-1:0]      out_cos,
    output logic signed [XW-1:0]      out_sin
);

    logic                 valid_reg [CORDIC_STAGES];
    logic signed [XW-1:0] x_reg     [CORDIC_STAGES];
    logic signed [XW-1:0] y_reg     [CORDIC_STAGES];
    logic signed [ZW-1:0] z_reg     [CORDIC_STAGES];
    track_t               tk_reg    [CORDIC_STAGES];

    logic                 v_in  [CORDIC_STAGES+1];
    logic signed [XW-1:0] x_in  [CORDIC_STAGES+1];
    logic signed [XW-1:0] y_in  [CORDIC_STAGES+1];
    logic signed [ZW-1:0] z_in  [CORDIC_STAGES+1];
    track_t               tk_in [CORDIC_STAGES+1];
    logic                 en    [CORDIC_STAGES+1];

    // Stage zero starts from the gain-scaled unit vector
    assign v_in[0]  = in_valid;
    assign x_in[0]  = CORDIC_GAIN;
    assign y_in[0]  = '0;
    assign z_in[0]  = in_z;
    assign tk_in[0] = in_track;
    assign en[CORDIC_STAGES] = out_ready;
    assign in_ready = en[0];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
        logic signed [XW-1:0] x_next, y_next;
        logic signed [ZW-1:0] z_next;
        logic                 valid_next;

        assign en[k]      = !valid_reg[k] || en[k+1];
        assign v_in[k+1]  = valid_reg[k];
        assign x_in[k+1]  = x_reg[k];
        assign y_in[k+1]  = y_reg[k];
        assign z_in[k+1]  = z_reg[k];
        assign tk_in[k+1] = tk_reg[k];

        // Rotate toward zero residual angle
        always_comb begin
            if (!z_in[k][ZW-1]) begin
                x_next = x_in[k] - (y_in[k] >>> k);
                y_next = y_in[k] + (x_in[k] >>> k);
                z_next = z_in[k] - cordic_atan(k);
            end else begin
                x_next = x_in[k] + (y_in[k] >>> k);
                y_next = y_in[k] - (x_in[k] >>> k);
                z_next = z_in[k] + cordic_atan(k);
            end
            valid_next = en[k] ? v_in[k] : valid_reg[k];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else begin
                valid_reg[k] <= valid_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (en[k]) begin
                x_reg[k]  <= x_next;
                y_reg[k]  <= y_next;
                z_reg[k]  <= z_next;
                tk_reg[k] <= tk_in[k];
            end
        end
    end

    assign out_valid = v_in[CORDIC_STAGES];
    assign out_track = tk_in[CORDIC_STAGES];
    assign out_cos   = x_in[CORDIC_STAGES];
    assign out_sin   = y_in[CORDIC_STAGES];

endmodule

`default_nettype wire

[design/sbw_scale.sv]
// Back end: quadrant fold and rounding, range products, position sums.
`default_nettype none

module sbw_scale import sbw_pkg::*; #(
    parameter int unsigned TRIG_FRAC_BITS = SBW_TRIG_FRAC_BITS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire track_t               in_track,
    input  wire logic signed [XW-1:0] in_cos,
    input  wire logic signed [XW-1:0] in_sin,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output out_t                      out_data
);

    localparam int unsigned SH = 30 - TRIG_FRAC_BITS;
    localparam int unsigned TW = TRIG_FRAC_BITS + 2;
    localparam int unsigned PW = TRIG_FRAC_BITS + 19;
    localparam logic signed [XW-1:0] TRIG_HALF = XW'(64'd1 << (SH - 1));
    localparam logic signed [PW-1:0] PROD_HALF = PW'(64'd1 << (TRIG_FRAC_BITS - 1));

    logic                 v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic                 en1, en2, en3;
    logic signed [TW-1:0] cos1_reg, cos1_next, sin1_reg, sin1_next;
    side_t                side1_reg, side2_reg;
    logic signed [PW-1:0] pc2_reg, pc2_next, ps2_reg, ps2_next;
    out_t                 out3_reg, out3_next;

    logic signed [XW-1:0] cq, sq, cr, sr;
    logic signed [PW-1:0] mmx, mmy;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Fold the quadrant back in, then round to the trig fraction width
    always_comb begin
        unique case (in_track.quad)
            QUAD_1: begin
                cq = -in_sin;
                sq = in_cos;
            end
            QUAD_2: begin
                cq = -in_cos;
                sq = -in_sin;
            end
            QUAD_3: begin
                cq = in_sin;
                sq = -in_cos;
            end
            default: begin
                cq = in_cos;
                sq = in_sin;
            end
        endcase
        cr        = (cq + TRIG_HALF) >>> SH;
        sr        = (sq + TRIG_HALF) >>> SH;
        cos1_next = TW'(cr);
        sin1_next = TW'(sr);
        v1_next   = en1 ? in_valid : v1_reg;
    end

    // Scale by range
    always_comb begin
        pc2_next = PW'($signed({1'b0, side1_reg.range}) * cos1_reg);
        ps2_next = PW'($signed({1'b0, side1_reg.range}) * sin1_reg);
        v2_next  = en2 ? v1_reg : v2_reg;
    end

    // Round to whole millimeters and add the robot position
    always_comb begin
        mmx                   = (pc2_reg + PROD_HALF) >>> TRIG_FRAC_BITS;
        mmy                   = (ps2_reg + PROD_HALF) >>> TRIG_FRAC_BITS;
        out3_next.obstacle_x  = side2_reg.rx + 32'(mmx);
        out3_next.obstacle_y  = side2_reg.ry + 32'(mmy);
        out3_next.source_beam = side2_reg.beam;
        v3_next               = en3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            cos1_reg  <= cos1_next;
            sin1_reg  <= sin1_next;
            side1_reg <= in_track.side;
        end
        if (en2) begin
            pc2_reg   <= pc2_next;
            ps2_reg   <= ps2_next;
            side2_reg <= side1_reg;
        end
        if (en3) begin
            out3_reg  <= out3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out3_reg;

endmodule

`default_nettype wire
